/* hw/rtl/bhpq_pkg.sv */
package bhpq_pkg;

    localparam int CAPACITY = 1023;
    localparam int KEY_W    = 32;
    localparam int DEPTH    = CAPACITY + 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(DEPTH);

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [ADDR_W-1:0]       t_addr;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_POP_RD,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/bhpq_ram.sv */
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/binary_max_heap_priority_queue.sv */
// Peek or rejected command goes straight to the result. Push walks the key up, reading and
// comparing the parent at each level; pop reads the last entry, walks it down, reading the
// children at each level. One word in work at a time; the next is accepted at the edge
// after the result is loaded into the output register. Each heap level costs RAM reads and a
// compare, so the sift walk sets the rate. Reset: synchronous, clears the count and handshake
// state; the heap RAM is not cleared, entries above the count are never read.
module binary_max_heap_priority_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_command,
    input  bhpq_pkg::t_key           i_key_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output bhpq_pkg::t_key           o_top_value,
    output logic                     o_top_valid,
    output logic [bhpq_pkg::CNT_W-1:0] o_entry_count,
    output logic [1:0]               o_status
);
    import bhpq_pkg::*;

    localparam t_addr ADDR_ROOT = t_addr'(1);
    localparam t_cnt  CNT_ONE   = t_cnt'(1);
    localparam t_cnt  CNT_FULL  = t_cnt'(CAPACITY);

    t_state  r_state, n_state;
    t_cnt    r_count, n_count;
    t_cnt    r_pos, n_pos;
    t_key    r_key, n_key;
    t_key    r_best, n_best;
    t_key    r_top, n_top;
    t_status r_status, n_status;
    logic    r_o_valid, n_o_valid;
    t_key    r_o_top, n_o_top;
    logic    r_o_top_valid, n_o_top_valid;
    t_cnt    r_o_count, n_o_count;
    t_status r_o_status, n_o_status;

    logic          ram_we, ram_re;
    t_addr         ram_waddr, ram_raddr;
    t_key          ram_wdata, ram_rdata;
    logic [CNT_W:0] w_left, w_right, w_cnt_ext;
    t_key          w_cand;
    t_cnt          w_cand_pos;

    // Reads never target an address written in the same or previous cycle: the walk
    // writes the current slot and reads only its parent or its children.
    bhpq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(DEPTH)
    ) u_heap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign w_left    = {r_pos, 1'b0};
    assign w_right   = w_left + 1'b1;
    assign w_cnt_ext = {1'b0, r_count};

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_key         = r_key;
        n_best        = r_best;
        n_status      = r_status;
        n_o_valid     = r_o_valid && i_stall;
        n_o_top       = r_o_top;
        n_o_top_valid = r_o_top_valid;
        n_o_count     = r_o_count;
        n_o_status    = r_o_status;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = t_addr'(r_pos);
        ram_wdata     = r_key;
        ram_raddr     = t_addr'(w_left[CNT_W-1:0]);

        // larger child candidate for the sift-down move
        if (r_state == S_DN_R && r_best < ram_rdata) begin
            w_cand     = ram_rdata;
            w_cand_pos = w_right[CNT_W-1:0];
        end else if (r_state == S_DN_R) begin
            w_cand     = r_best;
            w_cand_pos = w_left[CNT_W-1:0];
        end else begin
            w_cand     = ram_rdata;
            w_cand_pos = w_left[CNT_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = STAT_OK;
                    n_state  = S_DONE;
                    if (i_command == CMD_PUSH) begin
                        if (r_count >= CNT_FULL) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_count = r_count + CNT_ONE;
                            n_pos   = r_count + CNT_ONE;
                            n_key   = i_key_value;
                            n_state = S_UP;
                        end
                    end else if (i_command == CMD_POP) begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = t_addr'(r_count);
                            n_state   = S_POP_RD;
                        end
                    end
                end
            end
            S_UP: begin
                if (r_pos == CNT_ONE) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = t_addr'(r_pos >> 1);
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (r_key > ram_rdata) begin
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos >> 1;
                    n_state   = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_RD: begin
                n_key   = ram_rdata;
                n_count = r_count - CNT_ONE;
                n_pos   = CNT_ONE;
                n_state = S_DN;
            end
            S_DN: begin
                if (w_left > w_cnt_ext) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_DN_L;
                end
            end
            S_DN_L, S_DN_R: begin
                if (r_state == S_DN_L && w_right <= w_cnt_ext) begin
                    n_best    = ram_rdata;
                    ram_re    = 1'b1;
                    ram_raddr = t_addr'(w_right[CNT_W-1:0]);
                    n_state   = S_DN_R;
                end else begin
                    ram_we = 1'b1;
                    // only a strictly smaller child stops the walk
                    if (w_cand < r_key) begin
                        n_state = S_DONE;
                    end else begin
                        ram_wdata = w_cand;
                        n_pos     = w_cand_pos;
                        n_state   = S_DN;
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid     = 1'b1;
                    n_o_top_valid = (r_count != '0);
                    n_o_top       = (r_count != '0) ? r_top : '0;
                    n_o_count     = r_count;
                    n_o_status    = r_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // root copy kept beside the RAM so the result needs no extra read
        n_top = (ram_we && ram_waddr == ADDR_ROOT) ? ram_wdata : r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos         <= n_pos;
        r_key         <= n_key;
        r_best        <= n_best;
        r_top         <= n_top;
        r_status      <= n_status;
        r_o_top       <= n_o_top;
        r_o_top_valid <= n_o_top_valid;
        r_o_count     <= n_o_count;
        r_o_status    <= n_o_status;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_top_value   = r_o_top;
    assign o_top_valid   = r_o_top_valid;
    assign o_entry_count = r_o_count;
    assign o_status      = r_o_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("heap count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_FULL |-> o_entry_count == CNT_FULL)
        else $error("full status with heap not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_EMPTY |-> o_entry_count == '0 && !o_top_valid)
        else $error("empty status with keys held");

    a_top_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_top_valid == (o_entry_count != '0))
        else $error("top valid disagrees with count");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !o_valid |=> r_state == S_IDLE && o_valid)
        else $error("result not loaded from done");

endmodule

/* tb/tb_binary_max_heap_priority_queue.sv */
module tb_binary_max_heap_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import bhpq_pkg::*;

    localparam int         LIMIT_CYCLES = 1_000_000;
    localparam int         DRAIN_CYCLES = 40;
    localparam logic [1:0] CMD_SPARE    = 2'd3;   // unused encoding, acts as a peek
    localparam t_key       KEY_MAX      = 32'sh7FFF_FFFF;
    localparam t_key       KEY_MIN      = 32'sh8000_0000;

    typedef struct {
        t_key    top;
        logic    top_ok;
        t_cnt    count;
        t_status stat;
    } t_heap_view;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_stall     = 1'b0;
    logic [1:0] i_command   = CMD_PEEK;
    t_key       i_key_value = '0;
    logic       o_stall;
    logic       o_valid;
    t_key       o_top_value;
    logic       o_top_valid;
    t_cnt       o_entry_count;
    logic [1:0] o_status;

    // predicted heap contents, one-based like the block
    t_key       heap_mem [1:CAPACITY];
    int         heap_size = 0;
    t_heap_view heap_views_due [$];

    int   fails     = 0;
    int   cycles    = 0;
    bit   idle_on   = 1'b1;
    int   hold_seq  = 0;
    int   hold_seen = 0;
    int   hold_len  = 0;
    int   hold_left = 0;

    binary_max_heap_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_key_value   (i_key_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_top_value   (o_top_value),
        .o_top_valid   (o_top_valid),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls while idle_on is set, plus a long hold whenever a test bumps hold_seq
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (idle_on) begin
            i_stall <= ($urandom_range(99) < 30);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // apply one command to the predicted heap and return the word it should produce
    function automatic t_heap_view heap_step(input logic [1:0] cmd, input t_key key);
        t_heap_view v;
        int         pos;
        int         child;
        bit         walking;
        t_key       tmp;
        v.stat = STAT_OK;
        if (cmd == CMD_PUSH) begin
            if (heap_size >= CAPACITY) begin
                v.stat = STAT_FULL;
            end else begin
                heap_size++;
                heap_mem[heap_size] = key;
                pos = heap_size;
                while (pos > 1 && heap_mem[pos / 2] < heap_mem[pos]) begin
                    tmp = heap_mem[pos];
                    heap_mem[pos] = heap_mem[pos / 2];
                    heap_mem[pos / 2] = tmp;
                    pos = pos / 2;
                end
            end
        end else if (cmd == CMD_POP) begin
            if (heap_size == 0) begin
                v.stat = STAT_EMPTY;
            end else begin
                heap_mem[1] = heap_mem[heap_size];
                heap_size--;
                pos = 1;
                walking = 1'b1;
                while (walking && pos * 2 <= heap_size) begin
                    child = pos * 2;
                    if (child + 1 <= heap_size && heap_mem[child] < heap_mem[child + 1])
                        child++;
                    // equal child still swaps; only a strictly smaller one stops the walk
                    if (heap_mem[child] < heap_mem[pos]) begin
                        walking = 1'b0;
                    end else begin
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[child];
                        heap_mem[child] = tmp;
                        pos = child;
                    end
                end
            end
        end
        v.top_ok = (heap_size > 0);
        v.top    = v.top_ok ? heap_mem[1] : '0;
        v.count  = t_cnt'(heap_size);
        return v;
    endfunction

    always @(posedge i_clk) begin : check_word
        t_heap_view want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (heap_views_due.size() == 0) begin
                $display("%0t: unexpected word, top %0d count %0d status %0d",
                         $time, o_top_value, o_entry_count, o_status);
                fails++;
            end else begin
                want = heap_views_due.pop_front();
                if (o_top_value !== want.top) begin
                    $display("%0t: top_value expected %0d actual %0d",
                             $time, want.top, o_top_value);
                    fails++;
                end
                if (o_top_valid !== want.top_ok) begin
                    $display("%0t: top_valid expected %0d actual %0d",
                             $time, want.top_ok, o_top_valid);
                    fails++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    fails++;
                end
                if (o_status !== want.stat) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.stat, o_status);
                    fails++;
                end
            end
        end
    end

    // optional idle gap first, then offer the word until it is taken
    task automatic send_word(input logic [1:0] cmd, input t_key key);
        int gap;
        if (idle_on && $urandom_range(99) < 30) begin
            gap = $urandom_range(2, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_key_value <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        heap_views_due.push_back(heap_step(cmd, key));
    endtask

    task automatic drain_results;
        i_valid <= 1'b0;
        while (heap_views_due.size() != 0) @(posedge i_clk);
    endtask

    // small keys give plenty of ties, extremes hit the sign boundary
    function automatic t_key pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return t_key'(int'($urandom_range(8)) - 4);
        else if (r < 35)
            return $urandom_range(1) ? KEY_MAX : KEY_MIN;
        else
            return t_key'($urandom());
    endfunction

    function automatic logic [1:0] pick_command(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return CMD_PUSH;
        else if (r < push_pct + pop_pct)
            return CMD_POP;
        else if (r < 95)
            return CMD_PEEK;
        else
            return CMD_SPARE;
    endfunction

    task automatic test_empty_queue;
        send_word(CMD_PEEK, KEY_MAX);
        send_word(CMD_POP, KEY_MIN);
        send_word(CMD_SPARE, KEY_MAX);
        drain_results;
    endtask

    task automatic test_key_extremes;
        send_word(CMD_PUSH, KEY_MIN);
        send_word(CMD_PUSH, '0);
        send_word(CMD_PUSH, -32'sd1);
        send_word(CMD_PUSH, KEY_MAX);
        send_word(CMD_PUSH, KEY_MAX);
        send_word(CMD_PEEK, KEY_MIN);
        send_word(CMD_SPARE, '0);
        repeat (6) send_word(CMD_POP, '0);
        drain_results;
    endtask

    task automatic test_equal_keys;
        send_word(CMD_PUSH, 32'sd7);
        send_word(CMD_PUSH, 32'sd7);
        send_word(CMD_PUSH, 32'sd3);
        send_word(CMD_PUSH, 32'sd7);
        send_word(CMD_PUSH, 32'sd7);
        repeat (5) send_word(CMD_POP, '0);
        drain_results;
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_word(pick_command(45, 40), pick_key());
        drain_results;
    endtask

    task automatic test_no_idle;
        idle_on = 1'b0;
        test_random_mix(150);
        idle_on = 1'b1;
    endtask

    // receiver holds off long enough for the input side to back up
    task automatic test_backpressure;
        hold_len <= 300;
        hold_seq <= hold_seq + 1;
        repeat (30) send_word(pick_command(60, 30), pick_key());
        drain_results;
    endtask

    // ascending ramp keys, mixed with random ones, each climb above all earlier ramp keys
    task automatic test_fill_and_reject;
        t_key ramp;
        ramp = KEY_MIN;
        while (heap_size < CAPACITY) begin
            if ($urandom_range(99) < 30) begin
                send_word(CMD_PUSH, ramp);
                ramp = ramp + 32'sd4_000_000;
            end else begin
                send_word(CMD_PUSH, pick_key());
            end
        end
        repeat (5) send_word(CMD_PUSH, pick_key());
        send_word(CMD_PEEK, '0);
        drain_results;
    endtask

    task automatic test_pop_heavy(input int n);
        repeat (n) send_word(pick_command(10, 85), pick_key());
        drain_results;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue;
        test_key_extremes;
        test_equal_keys;
        test_random_mix(300);
        test_no_idle;
        test_backpressure;
        test_fill_and_reject;
        test_pop_heavy(450);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bhpq_pkg.sv
hw/rtl/bhpq_ram.sv
hw/rtl/binary_max_heap_priority_queue.sv
tb/tb_binary_max_heap_priority_queue.sv
